// ----- hw/rtl/wsa_pkg.sv -----
`default_nettype none
package wsa_pkg;

   localparam int NumSeriesDefault = 16;
   localparam int SeriesWidth = 4;

   localparam logic [26:0] MaxWindowMs = 27'd86400000;
   localparam logic [26:0] RampStartMs = 27'd5000;
   localparam logic [26:0] ResetWindowMs = 27'd60000;
   localparam logic [26:0] RampStepMs = 27'd2000;

   localparam logic [2:0] CmdSample = 3'd0;
   localparam logic [2:0] CmdCheck = 3'd1;
   localparam logic [2:0] CmdSetWindow = 3'd2;
   localparam logic [2:0] CmdClear = 3'd3;
   localparam logic [2:0] CmdRampTick = 3'd4;

   localparam logic [0:0] RegDefaultWindow = 1'd0;
   localparam logic [0:0] RegFastStart = 1'd1;

   typedef struct packed {
      logic [2:0] cmd;
      logic [3:0] series;
      logic signed [31:0] value;
      logic [31:0] now;
      logic [26:0] duration;
   } req_type;

   typedef struct packed {
      logic [3:0] report_series;
      logic [31:0] open_time;
      logic [31:0] close_time;
      logic signed [31:0] minimum;
      logic signed [31:0] maximum;
      logic signed [31:0] average;
      logic [31:0] sample_count;
      logic last;
   } rsp_type;

   // divider request/result
   typedef struct packed {
      logic start;
      logic signed [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic signed [31:0] quotient;
   } div_rsp_type;

   function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if (!a[63] && !b[63] && s[63]) sat_add64 = {1'b0, {63{1'b1}}};
      else if (a[63] && b[63] && !s[63]) sat_add64 = {1'b1, 63'd0};
      else sat_add64 = s;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/wsa_divider.sv -----
`default_nettype none
// restoring divider, one quotient bit per cycle, result saturated to 32 bits
module wsa_divider (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire wsa_pkg::div_req_type  div_req,
   output wsa_pkg::div_rsp_type       div_rsp
);
   logic [6:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic neg_ff, neg_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [64:0] trial;
   logic [63:0] mag;
   logic signed [64:0] sq;

   always_comb begin
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in = neg_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      trial = {rem_ff, quo_ff[63]} - {33'd0, den_ff};
      mag = div_req.dividend[63] ? (~div_req.dividend + 64'd1) : div_req.dividend;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in = 7'd0;
         neg_in = div_req.dividend[63];
         quo_in = mag;
         rem_in = 64'd0;
         den_in = div_req.divisor;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[62:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= 7'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   always_comb begin
      sq = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      div_rsp.busy = busy_ff;
      div_rsp.done = done_ff;
      if (den_ff == 32'd0) div_rsp.quotient = 32'sd0;
      else if (sq > 65'sh7FFFFFFF) div_rsp.quotient = 32'h7FFFFFFF;
      else if (sq < -65'sh80000000) div_rsp.quotient = 32'h80000000;
      else div_rsp.quotient = sq[31:0];
   end

`ifndef SYNTH
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> $past(busy_ff)) else $error("done without busy");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff) else $error("start while busy");
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> !busy_ff) else $error("done while busy");
`endif
endmodule
`default_nettype wire

// ----- hw/rtl/windowed_series_aggregator_unit.sv -----
`default_nettype none
// windowed series aggregator: per-series min, max, sample count and time-weighted
// sum, held in small memories indexed by series and worked on one series at a time
// through a working copy, one shared multiplier, one saturating adder and a shared
// bit-serial divider. req_stall is high whenever a transaction is in flight.
// a sample or set-window stalls the input until its series is written back, first
// creating the series if it is new; clear and ramp tick finish in the accepting
// cycle with no stall. a check tick walks every series, skipping those absent or
// not expired, closing an expired empty window with no report and passing each
// other window through the 64-step divider, then releases the final report. a
// report waits in a one-entry hold register until the walk shows whether another
// follows, which sets its last bit; when both the hold and the output register are
// full, the walk pauses for as long as the result channel stalls. no clearing pass:
// entry and previous-value flags sit in flip-flops.
module windowed_series_aggregator_unit #(
   parameter int NUM_SERIES = wsa_pkg::NumSeriesDefault
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire wsa_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output wsa_pkg::rsp_type       rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [2:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   localparam int IW = (NUM_SERIES > 1) ? $clog2(NUM_SERIES) : 1;
   localparam int XW = IW + 1;

   // sequencer states
   localparam logic [3:0] StIdle  = 4'd0;
   localparam logic [3:0] StRead  = 4'd1;
   localparam logic [3:0] StPrep  = 4'd2;
   localparam logic [3:0] StMul   = 4'd3;
   localparam logic [3:0] StSum   = 4'd4;
   localparam logic [3:0] StApply = 4'd5;
   localparam logic [3:0] StDiv   = 4'd6;
   localparam logic [3:0] StWait  = 4'd7;
   localparam logic [3:0] StOut   = 4'd8;
   localparam logic [3:0] StNext  = 4'd9;
   localparam logic [3:0] StFlush = 4'd10;

   // config registers
   logic [26:0] dwin_ff;
   logic fast_ff;
   logic [26:0] ramp_ff, ramp_in;
   logic cfg_wr;
   logic [26:0] wv, wc;

   // per-series storage
   logic [NUM_SERIES-1:0] exists_ff, exists_in, hasprev_ff, hasprev_in;
   logic [26:0] ovr_mem [NUM_SERIES];
   logic [31:0] wst_mem [NUM_SERIES];
   logic [31:0] wend_mem [NUM_SERIES];
   logic [31:0] lst_mem [NUM_SERIES];
   logic [31:0] prev_mem [NUM_SERIES];
   logic [31:0] min_mem [NUM_SERIES];
   logic [31:0] max_mem [NUM_SERIES];
   logic [63:0] sum_mem [NUM_SERIES];
   logic [31:0] cnt_mem [NUM_SERIES];

   // working copy of one series
   logic [26:0] ovr_ff, ovr_in;
   logic [31:0] wst_ff, wst_in, wend_ff, wend_in, lst_ff, lst_in;
   logic [31:0] prev_ff, prev_in, min_ff, min_in, max_ff, max_in, cnt_ff, cnt_in;
   logic [63:0] sum_ff, sum_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] upto_ff, upto_in;
   logic wr_en;

   logic [3:0] st_ff, st_in;
   wsa_pkg::req_type rq_ff, rq_in;
   logic [IW:0] idx_ff, idx_in;
   logic [IW-1:0] ix;
   logic rv_ff, rv_in;
   wsa_pkg::rsp_type rsp_ff, rsp_in;
   logic hold_ff, hold_in;
   wsa_pkg::rsp_type hold_data_ff, hold_data_in;
   wsa_pkg::rsp_type rep;
   logic out_free;
   logic [26:0] pick;
   logic [26:0] ramp_pick;
   logic expired;
   logic [31:0] span;
   logic [31:0] held;
   logic [63:0] sum_next;
   logic more;
   logic [IW:0] nidx;

   wsa_pkg::div_req_type div_req;
   wsa_pkg::div_rsp_type div_rsp;

   wsa_divider u_div (.clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp));

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;
   always_comb begin
      wv = pwdata[26:0];
      wc = (wv > wsa_pkg::MaxWindowMs) ? wsa_pkg::MaxWindowMs : wv;
      if (wc == 27'd0) wc = 27'd1;
      case (paddr[2])
         wsa_pkg::RegDefaultWindow: prdata = {5'd0, dwin_ff};
         wsa_pkg::RegFastStart: prdata = {31'd0, fast_ff};
         default: prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dwin_ff <= wsa_pkg::ResetWindowMs;
         fast_ff <= 1'b1;
      end else if (cfg_wr) begin
         if (paddr[2] == wsa_pkg::RegDefaultWindow) dwin_ff <= wc;
         else if (paddr[2] == wsa_pkg::RegFastStart) fast_ff <= pwdata[0];
      end
   end

   assign ix = idx_ff[IW-1:0];
   assign req_stall = reset || (st_ff != StIdle);
   assign rsp_valid = rv_ff;
   assign rsp_data = rsp_ff;

   // window choice for the series in the working copy
   always_comb begin
      ramp_pick = (ramp_ff == 27'd0) ? wsa_pkg::RampStartMs : ramp_ff;
      if (ovr_ff != 27'd0) pick = ovr_ff;
      else if (fast_ff) pick = ramp_pick;
      else pick = dwin_ff;
   end

   always_ff @(posedge clock) begin
      if (st_ff == StRead) begin
         ovr_ff <= ovr_mem[ix];
         wst_ff <= wst_mem[ix];
         wend_ff <= wend_mem[ix];
         lst_ff <= lst_mem[ix];
         prev_ff <= prev_mem[ix];
         min_ff <= min_mem[ix];
         max_ff <= max_mem[ix];
         sum_ff <= sum_mem[ix];
         cnt_ff <= cnt_mem[ix];
      end else begin
         ovr_ff <= ovr_in;
         wst_ff <= wst_in;
         wend_ff <= wend_in;
         lst_ff <= lst_in;
         prev_ff <= prev_in;
         min_ff <= min_in;
         max_ff <= max_in;
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
      end
      if (wr_en) begin
         ovr_mem[ix] <= ovr_ff;
         wst_mem[ix] <= wst_ff;
         wend_mem[ix] <= wend_ff;
         lst_mem[ix] <= lst_ff;
         prev_mem[ix] <= prev_ff;
         min_mem[ix] <= min_ff;
         max_mem[ix] <= max_ff;
         sum_mem[ix] <= sum_ff;
         cnt_mem[ix] <= cnt_ff;
      end
      prod_ff <= prod_in;
      upto_ff <= upto_in;
      rq_ff <= rq_in;
      rsp_ff <= rsp_in;
      hold_data_ff <= hold_data_in;
   end

   always_comb begin
      st_in = st_ff;
      rq_in = rq_ff;
      idx_in = idx_ff;
      rsp_in = rsp_ff;
      hold_in = hold_ff;
      hold_data_in = hold_data_ff;
      exists_in = exists_ff;
      hasprev_in = hasprev_ff;
      ramp_in = ramp_ff;
      ovr_in = ovr_ff;
      wst_in = wst_ff;
      wend_in = wend_ff;
      lst_in = lst_ff;
      prev_in = prev_ff;
      min_in = min_ff;
      max_in = max_ff;
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      prod_in = prod_ff;
      upto_in = upto_ff;
      wr_en = 1'b0;
      div_req = '0;
      span = wend_ff - rq_ff.now;
      expired = (span == 32'd0) || span[31];
      nidx = idx_ff + 1'b1;
      more = (nidx < NUM_SERIES);
      // shared multiplier operand: time the previous value was held
      held = (rq_ff.cmd == wsa_pkg::CmdCheck) ? (wend_ff - lst_ff) : (upto_ff - lst_ff);
      // shared saturating adder
      sum_next = wsa_pkg::sat_add64(sum_ff, prod_ff);
      out_free = !rv_ff || !rsp_stall;
      rv_in = rv_ff && rsp_stall;

      rep.report_series = 4'(idx_ff);
      rep.open_time = wst_ff;
      rep.close_time = wend_ff;
      rep.minimum = min_ff;
      rep.maximum = max_ff;
      rep.average = div_rsp.quotient;
      rep.sample_count = cnt_ff;
      rep.last = 1'b0;

      case (st_ff)
         StIdle: begin
            if (req_valid) begin
               rq_in = req_data;
               idx_in = '0;
               case (req_data.cmd)
                  wsa_pkg::CmdSample, wsa_pkg::CmdSetWindow: begin
                     idx_in = XW'(req_data.series);
                     if (32'(req_data.series) < NUM_SERIES) st_in = StRead;
                  end
                  wsa_pkg::CmdCheck: st_in = StRead;
                  wsa_pkg::CmdClear: begin
                     exists_in = '0;
                     hasprev_in = '0;
                     ramp_in = 27'd0;
                  end
                  wsa_pkg::CmdRampTick: begin
                     if (ramp_ff != 27'd0) begin
                        ramp_in = (ramp_ff < dwin_ff) ? ramp_ff + wsa_pkg::RampStepMs
                                                       : ramp_ff;
                        if (ramp_in > dwin_ff) ramp_in = dwin_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end
         StRead: st_in = StPrep;
         StPrep: begin
            if (rq_ff.cmd == wsa_pkg::CmdCheck) begin
               if (!exists_ff[ix] || !expired) st_in = StNext;
               else st_in = StMul;
            end else if (!exists_ff[ix]) begin
               // create series, then rerun prep on the fresh entry
               exists_in[ix] = 1'b1;
               hasprev_in[ix] = 1'b0;
               ovr_in = 27'd0;
               prev_in = 32'd0;
               min_in = 32'd0;
               max_in = 32'd0;
               sum_in = 64'd0;
               cnt_in = 32'd0;
               lst_in = 32'd0;
               wst_in = rq_ff.now;
               if (fast_ff && ramp_ff == 27'd0) ramp_in = wsa_pkg::RampStartMs;
               wend_in = rq_ff.now + {5'd0, (fast_ff ? ramp_pick : dwin_ff)};
            end else if (rq_ff.cmd == wsa_pkg::CmdSetWindow) begin
               ovr_in = (rq_ff.duration > wsa_pkg::MaxWindowMs) ? wsa_pkg::MaxWindowMs
                                                               : rq_ff.duration;
               st_in = StApply;
            end else begin
               if (!hasprev_ff[ix]) begin
                  // first value is weighted back to the window start
                  hasprev_in[ix] = 1'b1;
                  prev_in = rq_ff.value;
                  min_in = rq_ff.value;
                  max_in = rq_ff.value;
                  sum_in = 64'd0;
                  cnt_in = 32'd0;
                  lst_in = wst_ff;
               end
               // late sample stops at the window end
               upto_in = expired ? wend_ff : rq_ff.now;
               st_in = StMul;
            end
         end
         StMul: begin
            prod_in = 64'($signed(prev_ff) * $signed({1'b0, held}));
            st_in = (rq_ff.cmd == wsa_pkg::CmdCheck) ? StSum : StApply;
         end
         StSum: begin
            // final term of the weighted sum
            sum_in = sum_next;
            if (cnt_ff == 32'd0) begin
               // empty window: no report, previous value forgotten
               hasprev_in[ix] = 1'b0;
               st_in = StApply;
            end else begin
               st_in = StDiv;
            end
         end
         StDiv: begin
            div_req.start = 1'b1;
            div_req.dividend = sum_ff;
            div_req.divisor = wend_ff - wst_ff;
            st_in = StWait;
         end
         StWait: begin
            if (div_rsp.done) st_in = StOut;
         end
         StOut: begin
            // a held report goes out as not-last once a newer one exists
            if (!hold_ff || out_free) begin
               if (hold_ff) begin
                  rv_in = 1'b1;
                  rsp_in = hold_data_ff;
                  rsp_in.last = 1'b0;
               end
               hold_in = 1'b1;
               hold_data_in = rep;
               st_in = StApply;
            end
         end
         StApply: begin
            if (rq_ff.cmd == wsa_pkg::CmdSample) begin
               if (cnt_ff != 32'hFFFFFFFF) cnt_in = cnt_ff + 32'd1;
               sum_in = sum_next;
               lst_in = upto_ff;
               if ($signed(rq_ff.value) > $signed(max_ff)) max_in = rq_ff.value;
               if ($signed(rq_ff.value) < $signed(min_ff)) min_in = rq_ff.value;
               prev_in = rq_ff.value;
            end else if (rq_ff.cmd == wsa_pkg::CmdCheck) begin
               // next window starts where this one ended
               wst_in = wend_ff;
               if (ovr_ff == 27'd0 && fast_ff && ramp_ff == 27'd0)
                  ramp_in = wsa_pkg::RampStartMs;
               wend_in = wend_ff + {5'd0, pick};
               min_in = prev_ff;
               max_in = prev_ff;
               sum_in = 64'd0;
               cnt_in = 32'd0;
               lst_in = wend_ff;
            end
            st_in = StNext;
         end
         StNext: begin
            wr_en = 1'b1;
            if (rq_ff.cmd == wsa_pkg::CmdCheck && more) begin
               idx_in = nidx;
               st_in = StRead;
            end else if (hold_ff) begin
               st_in = StFlush;
            end else begin
               st_in = StIdle;
            end
         end
         StFlush: begin
            // end of walk: the held report is the last one
            if (out_free) begin
               rv_in = 1'b1;
               rsp_in = hold_data_ff;
               rsp_in.last = 1'b1;
               hold_in = 1'b0;
               st_in = StIdle;
            end
         end
         default: st_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= StIdle;
         exists_ff <= '0;
         hasprev_ff <= '0;
         ramp_ff <= 27'd0;
         rv_ff <= 1'b0;
         hold_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         st_ff <= st_in;
         exists_ff <= exists_in;
         hasprev_ff <= hasprev_in;
         ramp_ff <= ramp_in;
         rv_ff <= rv_in;
         hold_ff <= hold_in;
         idx_ff <= idx_in;
      end
   end

`ifndef SYNTH
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != StIdle) |-> req_stall) else $error("accepted while busy");
   a_hold_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("report dropped");
   a_data_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_data)) else $error("report changed");
   a_ramp_cap: assert property (@(posedge clock) disable iff (reset)
      ramp_ff <= wsa_pkg::MaxWindowMs) else $error("ramp above limit");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy) else $error("divide while busy");
`endif
endmodule
`default_nettype wire

// ----- test/tb_windowed_series_aggregator_unit.sv -----
`timescale 1ns / 1ps
module tb_windowed_series_aggregator_unit;

   localparam int NumSeries = 16;
   localparam int CycleLimit = 3000000;
   localparam int SettleCycles = 400;
   localparam int LongHoldCycles = 3000;
   localparam logic [2:0] AddrDefaultWindow = 3'd4 * wsa_pkg::RegDefaultWindow;
   localparam logic [2:0] AddrFastStart = 3'd4 * wsa_pkg::RegFastStart;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   wsa_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   wsa_pkg::rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   windowed_series_aggregator_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #2 clock = ~clock;

   // transactions waiting to be offered, and reports the aggregator still owes us
   wsa_pkg::req_type pending_items[$];
   wsa_pkg::rsp_type expected_reports[$];
   int failures = 0;
   int cycles = 0;
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   int hold_ask = 0;
   logic [31:0] cur_now;

   // predicted aggregator state
   logic [26:0] pred_default_window;
   logic pred_fast_start;
   logic [26:0] pred_ramp;
   logic ser_exists [NumSeries];
   logic ser_has_prev [NumSeries];
   logic [26:0] ser_override [NumSeries];
   logic [31:0] ser_start [NumSeries];
   logic [31:0] ser_end [NumSeries];
   logic [31:0] ser_last_time [NumSeries];
   logic signed [31:0] ser_prev [NumSeries];
   logic signed [31:0] ser_min [NumSeries];
   logic signed [31:0] ser_max [NumSeries];
   longint ser_sum [NumSeries];
   logic [31:0] ser_count [NumSeries];

   function automatic longint add_saturated(longint a, longint b);
      longint s;
      s = a + b;
      if (a >= 0 && b >= 0 && s < 0) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (a < 0 && b < 0 && s >= 0) return 64'sh8000_0000_0000_0000;
      return s;
   endfunction

   // "t has passed": signed distance to now is negative
   function automatic logic has_passed(logic [31:0] t, logic [31:0] now);
      logic [31:0] d;
      d = t - now;
      return d[31];
   endfunction

   function automatic logic [26:0] choose_window(int s);
      if (ser_override[s] != 0) return ser_override[s];
      if (pred_fast_start) begin
         // fast-start seeding
         if (pred_ramp == 0) pred_ramp = wsa_pkg::RampStartMs;
         return pred_ramp;
      end
      return pred_default_window;
   endfunction

   function automatic void restart_window_stats(int s);
      ser_min[s] = ser_prev[s];
      ser_max[s] = ser_prev[s];
      ser_sum[s] = 0;
      ser_count[s] = 0;
      ser_last_time[s] = ser_start[s];
   endfunction

   function automatic void open_series(int s, logic [31:0] now);
      ser_exists[s] = 1'b1;
      ser_has_prev[s] = 1'b0;
      ser_override[s] = '0;
      ser_prev[s] = 0;
      ser_min[s] = 0;
      ser_max[s] = 0;
      ser_sum[s] = 0;
      ser_count[s] = 0;
      ser_last_time[s] = 0;
      ser_start[s] = now;
      ser_end[s] = now + 32'(choose_window(s));
   endfunction

   function automatic void record_sample(int s, logic signed [31:0] v, logic [31:0] now);
      logic [31:0] upto;
      logic [31:0] held;
      if (!ser_has_prev[s]) begin
         // first value is weighted back to the window start
         ser_has_prev[s] = 1'b1;
         ser_prev[s] = v;
         restart_window_stats(s);
      end
      if (ser_count[s] != 32'hFFFF_FFFF) ser_count[s]++;
      // late sample: previous value only counts up to the window end
      upto = has_passed(ser_end[s], now) ? ser_end[s] : now;
      held = upto - ser_last_time[s];
      ser_sum[s] = add_saturated(ser_sum[s], longint'(ser_prev[s]) * longint'(held));
      ser_last_time[s] = upto;
      if (v > ser_max[s]) ser_max[s] = v;
      if (v < ser_min[s]) ser_min[s] = v;
      ser_prev[s] = v;
   endfunction

   function automatic void close_expired_windows(logic [31:0] now);
      int n;
      logic [31:0] d;
      logic [31:0] len;
      logic [31:0] held;
      longint total;
      longint q;
      wsa_pkg::rsp_type r;
      n = 0;
      for (int s = 0; s < NumSeries; s++) begin
         d = ser_end[s] - now;
         if (!ser_exists[s] || (d != 0 && !d[31])) continue;
         if (ser_count[s] == 0) begin
            // empty window: no report, previous value forgotten
            ser_has_prev[s] = 1'b0;
         end else begin
            len = ser_end[s] - ser_start[s];
            held = ser_end[s] - ser_last_time[s];
            total = add_saturated(ser_sum[s], longint'(ser_prev[s]) * longint'(held));
            q = (len != 0) ? total / longint'(len) : 0;
            if (q > 64'sd2147483647) q = 64'sd2147483647;
            if (q < -64'sd2147483648) q = -64'sd2147483648;
            r.report_series = 4'(s);
            r.open_time = ser_start[s];
            r.close_time = ser_end[s];
            r.minimum = ser_min[s];
            r.maximum = ser_max[s];
            r.average = 32'(q);
            r.sample_count = ser_count[s];
            r.last = 1'b0;
            expected_reports.push_back(r);
            n++;
         end
         ser_start[s] = ser_end[s];
         ser_end[s] = ser_end[s] + 32'(choose_window(s));
         restart_window_stats(s);
      end
      if (n > 0) expected_reports[expected_reports.size() - 1].last = 1'b1;
   endfunction

   function automatic void apply_transaction(wsa_pkg::req_type t);
      int s;
      s = int'(t.series);
      case (t.cmd)
         wsa_pkg::CmdSample: begin
            if (!ser_exists[s]) open_series(s, t.now);
            record_sample(s, t.value, t.now);
         end
         wsa_pkg::CmdCheck: close_expired_windows(t.now);
         wsa_pkg::CmdSetWindow: begin
            if (!ser_exists[s]) open_series(s, t.now);
            ser_override[s] = (t.duration > wsa_pkg::MaxWindowMs) ? wsa_pkg::MaxWindowMs
                                                                 : t.duration;
         end
         wsa_pkg::CmdClear: begin
            for (int i = 0; i < NumSeries; i++) begin
               ser_exists[i] = 1'b0;
               ser_has_prev[i] = 1'b0;
            end
            pred_ramp = '0;
         end
         wsa_pkg::CmdRampTick: begin
            if (pred_ramp != 0) begin
               if (pred_ramp < pred_default_window)
                  pred_ramp = pred_ramp + wsa_pkg::RampStepMs;
               if (pred_ramp > pred_default_window) pred_ramp = pred_default_window;
            end
         end
         default: ; // unknown command is dropped
      endcase
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, field, got, want);
      failures++;
   endtask

   task automatic compare_report(wsa_pkg::rsp_type got);
      wsa_pkg::rsp_type want;
      if (expected_reports.size() == 0) begin
         $display("unexpected report at cycle %0d for series %0d", cycles, got.report_series);
         failures++;
         return;
      end
      want = expected_reports.pop_front();
      if (got.report_series !== want.report_series)
         report_mismatch("report_series", 64'(got.report_series), 64'(want.report_series));
      if (got.open_time !== want.open_time)
         report_mismatch("open_time", 64'(got.open_time), 64'(want.open_time));
      if (got.close_time !== want.close_time)
         report_mismatch("close_time", 64'(got.close_time), 64'(want.close_time));
      if (got.minimum !== want.minimum)
         report_mismatch("minimum", 64'(got.minimum), 64'(want.minimum));
      if (got.maximum !== want.maximum)
         report_mismatch("maximum", 64'(got.maximum), 64'(want.maximum));
      if (got.average !== want.average)
         report_mismatch("average", 64'(got.average), 64'(want.average));
      if (got.sample_count !== want.sample_count)
         report_mismatch("sample_count", 64'(got.sample_count), 64'(want.sample_count));
      if (got.last !== want.last)
         report_mismatch("last", 64'(got.last), 64'(want.last));
   endtask

   // monitor: both channels sampled at the rising edge; the timeout check stays last
   always @(posedge clock) begin
      cycles <= cycles + 1;
      req_fire <= !reset && req_valid && !req_stall;
      rsp_fire <= !reset && rsp_valid && !rsp_stall;
      if (!reset && req_valid && !req_stall) apply_transaction(req_data);
      if (!reset && rsp_valid && !rsp_stall) compare_report(rsp_data);
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("windowed_series_aggregator_unit regression: fail");
         $finish;
      end
   end

   // driver: offers the next pending transaction after a random gap, holds it until taken
   int send_gap = 0;
   int send_burst = 0;
   always @(negedge clock) begin
      logic nv;
      wsa_pkg::req_type nd;
      nv = 1'b0;
      nd = req_data;
      if (reset) begin
         nv = 1'b0;
      end else if (req_valid && !req_fire) begin
         nv = 1'b1;
      end else if (send_gap > 0) begin
         send_gap--;
      end else if (pending_items.size() > 0) begin
         nd = pending_items.pop_front();
         nv = 1'b1;
         if (send_burst > 0) send_burst--;
         else if ($urandom_range(0, 25) == 0) send_burst = 20;
         send_gap = (send_burst > 0) ? 0 : $urandom_range(0, 8);
      end
      req_valid <= nv;
      req_data <= nd;
   end

   // receiver: random stall after each report, plus an occasional long hold-off
   int stall_left = 0;
   int stall_burst = 0;
   int hold_taken = 0;
   always @(negedge clock) begin
      logic ns;
      ns = 1'b0;
      if (hold_ask != hold_taken) begin
         hold_taken = hold_ask;
         stall_left = LongHoldCycles;
      end else if (rsp_fire && stall_left == 0) begin
         if (stall_burst > 0) stall_burst--;
         else if ($urandom_range(0, 15) == 0) stall_burst = 12;
         stall_left = (stall_burst > 0) ? 0 : $urandom_range(0, 8);
      end
      if (stall_left > 0) begin
         ns = 1'b1;
         stall_left--;
      end
      rsp_stall <= ns;
   end

   task automatic queue_item(logic [2:0] cmd, logic [3:0] s, logic [31:0] v,
                             logic [31:0] now, logic [26:0] dur);
      wsa_pkg::req_type t;
      t.cmd = cmd;
      t.series = s;
      t.value = v;
      t.now = now;
      t.duration = dur;
      pending_items.push_back(t);
   endtask

   // random traffic: mostly samples on a few series with time moving forward, some ticks,
   // window overrides, clears and ramp ticks, plus unknown commands and time jumps as noise
   task automatic queue_random(int n, int step_max, int tick_pct);
      int r;
      int done;
      logic [2:0] cmd;
      logic [31:0] v;
      logic [26:0] dur;
      done = 0;
      while (done < n) begin
         r = $urandom_range(0, 99);
         if (r < tick_pct) cmd = wsa_pkg::CmdCheck;
         else if (r < tick_pct + 8) cmd = wsa_pkg::CmdSetWindow;
         else if (r < tick_pct + 11) cmd = wsa_pkg::CmdClear;
         else if (r < tick_pct + 21) cmd = wsa_pkg::CmdRampTick;
         else if (r < tick_pct + 23) cmd = 3'($urandom_range(5, 7));
         else cmd = wsa_pkg::CmdSample;
         r = $urandom_range(0, 9);
         if (r == 0) v = 32'h8000_0000;
         else if (r == 1) v = 32'h7FFF_FFFF;
         else if (r < 5) v = $urandom;
         else v = 32'($signed($urandom_range(0, 2000)) - 1000);
         r = $urandom_range(0, 9);
         if (r < 2) dur = '0;
         else if (r < 4) dur = 27'($urandom);
         else dur = 27'($urandom_range(1, 20000));
         if ($urandom_range(0, 49) == 0) cur_now = $urandom;
         else cur_now = cur_now + $urandom_range(0, step_max);
         queue_item(cmd, ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3))
                                                    : 4'($urandom_range(0, 15)),
                    v, cur_now, dur);
         if (cmd <= wsa_pkg::CmdRampTick) done++;
      end
   endtask

   // wait for the sender and every owed report, then let the block settle
   task automatic wait_idle();
      while (pending_items.size() > 0 || req_valid || expected_reports.size() > 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= addr;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (addr == AddrDefaultWindow) begin
         // clamp to one day, zero becomes one
         if (data[26:0] > wsa_pkg::MaxWindowMs) pred_default_window = wsa_pkg::MaxWindowMs;
         else if (data[26:0] == 0) pred_default_window = 27'd1;
         else pred_default_window = data[26:0];
      end else begin
         pred_fast_start = data[0];
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   initial begin
      pred_default_window = wsa_pkg::ResetWindowMs;
      pred_fast_start = 1'b1;
      pred_ramp = '0;
      for (int i = 0; i < NumSeries; i++) begin
         ser_exists[i] = 1'b0;
         ser_has_prev[i] = 1'b0;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, every command, late, first and empty-window cases
      queue_item(wsa_pkg::CmdClear, 4'd0, 32'd0, 32'd1000, 27'd0);
      queue_item(wsa_pkg::CmdRampTick, 4'd0, 32'd0, 32'd1000, 27'd0);
      queue_item(wsa_pkg::CmdSample, 4'd0, 32'h8000_0000, 32'd1000, 27'd0);
      queue_item(wsa_pkg::CmdSample, 4'd0, 32'h7FFF_FFFF, 32'd2000, 27'd0);
      queue_item(wsa_pkg::CmdRampTick, 4'd0, 32'd0, 32'd2100, 27'd0);
      queue_item(wsa_pkg::CmdSetWindow, 4'd1, 32'd0, 32'd2500, 27'h7FF_FFFF);
      queue_item(wsa_pkg::CmdSetWindow, 4'd15, 32'd0, 32'd2600, 27'd0);
      queue_item(wsa_pkg::CmdSample, 4'd15, 32'd0, 32'd3000, 27'd0);
      queue_item(3'd7, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 27'h7FF_FFFF);
      queue_item(3'd5, 4'd2, 32'd5, 32'd3100, 27'd9);
      queue_item(3'd6, 4'd3, 32'd6, 32'd3200, 27'd9);
      queue_item(wsa_pkg::CmdSample, 4'd0, 32'hFFFF_FFFF, 32'd7000, 27'd0);
      queue_item(wsa_pkg::CmdCheck, 4'd0, 32'd0, 32'd9000, 27'd0);
      queue_item(wsa_pkg::CmdCheck, 4'd0, 32'd0, 32'd20000, 27'd0);
      queue_item(wsa_pkg::CmdSetWindow, 4'd0, 32'd0, 32'd20001, 27'd1);
      queue_item(wsa_pkg::CmdSample, 4'd2, 32'd12345, 32'hFFFF_FFF0, 27'd0);
      queue_item(wsa_pkg::CmdSample, 4'd3, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 27'd0);
      queue_item(wsa_pkg::CmdCheck, 4'd0, 32'd0, 32'hFFFF_FFFF, 27'd0);
      queue_item(wsa_pkg::CmdSample, 4'd3, 32'h8000_0000, 32'd0, 27'd0);
      queue_item(wsa_pkg::CmdCheck, 4'd0, 32'd0, 32'h0100_0000, 27'd0);
      queue_item(wsa_pkg::CmdClear, 4'd0, 32'd0, 32'h0100_0000, 27'd0);
      wait_idle();

      // short windows with fast start ramping
      csr_write(AddrDefaultWindow, 32'd7000);
      csr_write(AddrFastStart, 32'd1);
      cur_now = $urandom;
      queue_random(80, 1500, 18);
      wait_idle();

      // one ms windows, no ramp; receiver holds off so the input backs up
      csr_write(AddrDefaultWindow, 32'd0);
      csr_write(AddrFastStart, 32'd0);
      hold_ask++;
      queue_random(60, 40, 25);
      wait_idle();

      // clamped one-day default, times around the wrap point
      csr_write(AddrDefaultWindow, 32'h07FF_FFFF);
      cur_now = 32'hFFFF_0000 + $urandom_range(0, 32'hFFFF);
      queue_random(60, 20000, 15);
      wait_idle();

      // mid-range default with fast start again
      csr_write(AddrDefaultWindow, 32'd9000);
      csr_write(AddrFastStart, 32'd1);
      queue_random(100, 2500, 18);
      wait_idle();

      if (failures == 0) begin
         $display("windowed_series_aggregator_unit regression: pass");
      end else begin
         $display("windowed_series_aggregator_unit regression: fail");
      end
      $finish;
   end

endmodule

// ----- windowed_series_aggregator_unit.f -----
hw/rtl/wsa_pkg.sv
hw/rtl/wsa_divider.sv
hw/rtl/windowed_series_aggregator_unit.sv
test/tb_windowed_series_aggregator_unit.sv
